@@ src/ctc_pkg.sv @@
// Shared constants, codes and types of the centroid tracker core counter.
`default_nettype none

package ctc_pkg;

  localparam int MAX_OBJECTS = 64;
  localparam int SLOT_W      = $clog2(MAX_OBJECTS);
  localparam int FRAC_BITS   = 4;

  localparam int COORD_W   = 16;
  localparam int ID_W      = 16;
  localparam int AREA_IN_W = 25;
  localparam int AREA_W    = 32;
  localparam int STATUS_W  = 3;
  localparam int PIX_W     = 12;
  localparam int RADIUS_W  = 8;
  localparam int MIN_W     = 13;
  localparam int MAX_W     = 15;
  localparam int DIST_W    = 2 * COORD_W + 1;
  localparam int CORE_W    = PIX_W + FRAC_BITS;
  localparam int CMP_W     = (CORE_W > COORD_W) ? CORE_W : COORD_W;

  localparam int          RECIP_W     = 16;
  localparam logic [15:0] RECIP3      = 16'd21846;

  localparam int DATA_W    = 32;
  localparam int PADDR_W   = 5;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_LEFT   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_RIGHT  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_MIN    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_MAX    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_RADIUS = 3'd4;

  localparam logic [PIX_W-1:0]    RST_LEFT   = 12'd0;
  localparam logic [PIX_W-1:0]    RST_RIGHT  = 12'd4095;
  localparam logic [MIN_W-1:0]    RST_MIN    = 13'd50;
  localparam logic [MAX_W-1:0]    RST_MAX    = 15'd20000;
  localparam logic [RADIUS_W-1:0] RST_RADIUS = 8'd20;

  localparam logic [STATUS_W-1:0] ST_REJECT  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_TRACKED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_COUNTED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_SUMMARY = 3'd4;

  typedef struct packed {
    logic               counted;
    logic [ID_W-1:0]    id;
    logic [COORD_W-1:0] cy;
    logic [COORD_W-1:0] cx;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic              live;
    logic              sv;
    logic              last;
    logic [SLOT_W-1:0] idx;
  } tag_t;

  typedef struct packed {
    tag_t            tag;
    logic [ID_W-1:0] id;
    logic            counted;
  } dtag_t;

endpackage

`default_nettype wire

@@ src/centroid_tracker_core_counter.sv @@
// Top level: blob tracker sequencer, slot table, frame counter and register port.
// A blob passes through setup, a scan of all 64 slots through the RAM read port and shared
// distance unit, drain, update and output; a reject or end of frame item goes straight to
// output. The next item is taken only once the block is back in idle, and output stalls
// hold it in the output state. Reset empties the slot table, clears the id counter
// and frame total, and loads the register defaults.
`default_nettype none

module centroid_tracker_core_counter (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output      logic                              in_stall_o,
  input  wire logic                              action_i,
  input  wire logic [ctc_pkg::AREA_IN_W-1:0]     blob_area_x2_i,
  input  wire logic [ctc_pkg::COORD_W-1:0]       centroid_x_i,
  input  wire logic [ctc_pkg::COORD_W-1:0]       centroid_y_i,
  output      logic                              out_valid_o,
  input  wire logic                              out_stall_i,
  output      logic [ctc_pkg::STATUS_W-1:0]      status_o,
  output      logic [ctc_pkg::ID_W-1:0]          object_id_o,
  output      logic                              is_new_object_o,
  output      logic [ctc_pkg::AREA_W-1:0]        frame_area_x2_o,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [ctc_pkg::PADDR_W-1:0]       paddr,
  input  wire logic [ctc_pkg::DATA_W-1:0]        pwdata,
  output      logic [ctc_pkg::DATA_W-1:0]        prdata,
  output      logic                              pready
);

  localparam int          STATE_W  = 3;
  localparam logic [2:0]  S_IDLE   = 3'd0;
  localparam logic [2:0]  S_PREP   = 3'd1;
  localparam logic [2:0]  S_SCAN   = 3'd2;
  localparam logic [2:0]  S_DRAIN  = 3'd3;
  localparam logic [2:0]  S_DECIDE = 3'd4;
  localparam logic [2:0]  S_EMIT   = 3'd5;

  localparam int N   = ctc_pkg::MAX_OBJECTS;
  localparam int SW  = ctc_pkg::SLOT_W;
  localparam int PW  = ctc_pkg::PIX_W;
  localparam int DW  = ctc_pkg::DIST_W;
  localparam int AW  = ctc_pkg::AREA_W;
  localparam int CW  = ctc_pkg::CMP_W;
  localparam int RW  = ctc_pkg::RECIP_W;

  localparam logic [RW-1:0] RECIP3_EXT = ctc_pkg::RECIP3;

  logic [STATE_W-1:0] state_q;

  logic [PW-1:0]                   left_q, right_q;
  logic [ctc_pkg::MIN_W-1:0]       min_q;
  logic [ctc_pkg::MAX_W-1:0]       max_q;
  logic [ctc_pkg::RADIUS_W-1:0]    radius_q;

  logic [ctc_pkg::COORD_W-1:0]     x_q, y_q;
  logic [ctc_pkg::AREA_IN_W-1:0]   a2_q;

  logic                            neg_q;
  logic [PW-1:0]                   q1_q, q2_q, cs_q, ce_q;

  logic [SW-1:0]                   addr_q;
  logic                            free_found_q;
  logic [SW-1:0]                   free_idx_q;
  logic                            found_q;
  logic [DW-1:0]                   best_q;
  logic [SW-1:0]                   best_idx_q;
  logic [ctc_pkg::ID_W-1:0]        best_id_q;
  logic                            best_cnt_q;
  ctc_pkg::tag_t                   issue_tag_q;

  logic [N-1:0]                    valid_q, seen_q;
  logic [ctc_pkg::ID_W-1:0]        next_id_q;
  logic [AW-1:0]                   area_q;

  logic [ctc_pkg::STATUS_W-1:0]    res_status_q;
  logic [ctc_pkg::ID_W-1:0]        res_id_q;
  logic                            res_new_q;
  logic                            res_summary_q;

  logic                            cfg_we;
  logic [ctc_pkg::REG_IDX_W-1:0]   reg_idx;

  logic                            accept;
  logic                            reject;
  logic                            out_free;

  logic signed [PW:0]              span;
  logic [PW-1:0]                   mag;
  logic [PW+RW-1:0]                prod1;
  logic [PW+RW:0]                  prod2;

  ctc_pkg::entry_t                 rd_entry;
  ctc_pkg::entry_t                 wr_entry;
  logic                            ram_we;
  logic [SW-1:0]                   slot;
  ctc_pkg::dtag_t                  dtag_in, dtag_out;
  logic [DW-1:0]                   sq_dist;
  logic                            better;

  logic                            create;
  logic [ctc_pkg::ID_W-1:0]        sid;
  logic                            scnt;
  logic                            in_core;
  logic [AW:0]                     sum;
  logic [AW-1:0]                   sat_sum;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ctc_pkg::PADDR_W-1:2];
  assign cfg_we  = psel && penable && pwrite;

  always_comb begin
    case (reg_idx)
      ctc_pkg::REG_LEFT:   prdata = ctc_pkg::DATA_W'(left_q);
      ctc_pkg::REG_RIGHT:  prdata = ctc_pkg::DATA_W'(right_q);
      ctc_pkg::REG_MIN:    prdata = ctc_pkg::DATA_W'(min_q);
      ctc_pkg::REG_MAX:    prdata = ctc_pkg::DATA_W'(max_q);
      ctc_pkg::REG_RADIUS: prdata = ctc_pkg::DATA_W'(radius_q);
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= ctc_pkg::RST_LEFT;
      right_q  <= ctc_pkg::RST_RIGHT;
      min_q    <= ctc_pkg::RST_MIN;
      max_q    <= ctc_pkg::RST_MAX;
      radius_q <= ctc_pkg::RST_RADIUS;
    end else if (cfg_we) begin
      case (reg_idx)
        ctc_pkg::REG_LEFT:   left_q   <= pwdata[PW-1:0];
        ctc_pkg::REG_RIGHT:  right_q  <= pwdata[PW-1:0];
        ctc_pkg::REG_MIN:    min_q    <= pwdata[ctc_pkg::MIN_W-1:0];
        ctc_pkg::REG_MAX:    max_q    <= pwdata[ctc_pkg::MAX_W-1:0];
        ctc_pkg::REG_RADIUS: radius_q <= pwdata[ctc_pkg::RADIUS_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign reject     = (blob_area_x2_i == '0)
                   || (blob_area_x2_i < ctc_pkg::AREA_IN_W'({min_q, 1'b0}))
                   || (blob_area_x2_i > ctc_pkg::AREA_IN_W'({max_q, 1'b0}));
  assign out_free   = !out_valid_o || !out_stall_i;

  // Core region thirds: magnitude times a reciprocal of three, sign applied later.
  assign span  = $signed({1'b0, right_q}) - $signed({1'b0, left_q});
  assign mag   = span[PW] ? PW'(-span) : span[PW-1:0];
  assign prod1 = mag * RECIP3_EXT;
  assign prod2 = {mag, 1'b0} * RECIP3_EXT;

  assign dtag_in.tag     = issue_tag_q;
  assign dtag_in.id      = rd_entry.id;
  assign dtag_in.counted = rd_entry.counted;

  ctc_ram #(
    .WIDTH (ctc_pkg::ENTRY_W),
    .DEPTH (N)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot),
    .wdata_i (wr_entry),
    .raddr_i (addr_q),
    .rdata_o (rd_entry)
  );

  ctc_dist u_dist (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_entry_i (rd_entry),
    .ref_x_i    (x_q),
    .ref_y_i    (y_q),
    .tag_i      (dtag_in),
    .dist_o     (sq_dist),
    .tag_o      (dtag_out)
  );

  assign better = (sq_dist < best_q)
               || (found_q && (sq_dist == best_q) && (dtag_out.id < best_id_q));

  assign create  = !found_q && free_found_q;
  assign slot    = found_q ? best_idx_q : free_idx_q;
  assign sid     = found_q ? best_id_q : next_id_q;
  assign scnt    = found_q ? best_cnt_q : 1'b0;
  assign in_core = (CW'(x_q) >= CW'({cs_q, {ctc_pkg::FRAC_BITS{1'b0}}}))
                && (CW'(x_q) <= CW'({ce_q, {ctc_pkg::FRAC_BITS{1'b0}}}))
                && !scnt;
  assign sum     = {1'b0, area_q} + (AW + 1)'(a2_q);
  assign sat_sum = sum[AW] ? {AW{1'b1}} : sum[AW-1:0];

  assign ram_we           = (state_q == S_DECIDE) && (found_q || free_found_q);
  assign wr_entry.cx      = x_q;
  assign wr_entry.cy      = y_q;
  assign wr_entry.id      = sid;
  assign wr_entry.counted = scnt || in_core;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q  <= centroid_x_i;
      y_q  <= centroid_y_i;
      a2_q <= blob_area_x2_i;
    end
    if (state_q == S_PREP) begin
      neg_q <= span[PW];
      q1_q  <= prod1[PW+RW-1:RW];
      q2_q  <= prod2[PW+RW-1:RW];
    end
    if (state_q == S_SCAN) begin
      cs_q <= neg_q ? left_q - q1_q : left_q + q1_q;
      ce_q <= neg_q ? left_q - q2_q : left_q + q2_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_tag_q <= '0;
    end else if (state_q == S_SCAN) begin
      issue_tag_q.live <= 1'b1;
      issue_tag_q.sv   <= valid_q[addr_q];
      issue_tag_q.last <= (addr_q == SW'(N - 1));
      issue_tag_q.idx  <= addr_q;
    end else begin
      issue_tag_q <= '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if ((state_q == S_EMIT) && out_free) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      addr_q          <= '0;
      free_found_q    <= 1'b0;
      free_idx_q      <= '0;
      found_q         <= 1'b0;
      best_q          <= '0;
      best_idx_q      <= '0;
      best_id_q       <= '0;
      best_cnt_q      <= 1'b0;
      valid_q         <= '0;
      seen_q          <= '0;
      next_id_q       <= '0;
      area_q          <= '0;
      res_status_q    <= ctc_pkg::ST_REJECT;
      res_id_q        <= '0;
      res_new_q       <= 1'b0;
      res_summary_q   <= 1'b0;
      status_o        <= ctc_pkg::ST_REJECT;
      object_id_o     <= '0;
      is_new_object_o <= 1'b0;
      frame_area_x2_o <= '0;
    end else begin
      if (dtag_out.tag.live && dtag_out.tag.sv && better) begin
        found_q    <= 1'b1;
        best_q     <= sq_dist;
        best_idx_q <= dtag_out.tag.idx;
        best_id_q  <= dtag_out.id;
        best_cnt_q <= dtag_out.counted;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            res_id_q  <= '0;
            res_new_q <= 1'b0;
            if (action_i) begin
              res_summary_q <= 1'b1;
              res_status_q  <= ctc_pkg::ST_SUMMARY;
              state_q       <= S_EMIT;
            end else if (reject) begin
              res_summary_q <= 1'b0;
              res_status_q  <= ctc_pkg::ST_REJECT;
              state_q       <= S_EMIT;
            end else begin
              res_summary_q <= 1'b0;
              state_q       <= S_PREP;
            end
          end
        end
        S_PREP: begin
          best_q       <= DW'(radius_q) * DW'(radius_q) << (2 * ctc_pkg::FRAC_BITS);
          found_q      <= 1'b0;
          free_found_q <= 1'b0;
          addr_q       <= '0;
          state_q      <= S_SCAN;
        end
        S_SCAN: begin
          if (!valid_q[addr_q] && !free_found_q) begin
            free_found_q <= 1'b1;
            free_idx_q   <= addr_q;
          end
          addr_q <= addr_q + 1'b1;
          if (addr_q == SW'(N - 1)) begin
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (dtag_out.tag.live && dtag_out.tag.last) begin
            state_q <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (found_q || free_found_q) begin
            valid_q[slot] <= 1'b1;
            seen_q[slot]  <= 1'b1;
            if (create) begin
              next_id_q <= next_id_q + 1'b1;
            end
            if (in_core) begin
              area_q <= sat_sum;
            end
            res_status_q <= in_core ? ctc_pkg::ST_COUNTED : ctc_pkg::ST_TRACKED;
            res_id_q     <= sid;
            res_new_q    <= create;
          end else begin
            res_status_q <= ctc_pkg::ST_FULL;
            res_id_q     <= '0;
            res_new_q    <= 1'b0;
          end
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            status_o        <= res_status_q;
            object_id_o     <= res_id_q;
            is_new_object_o <= res_new_q;
            frame_area_x2_o <= area_q;
            if (res_summary_q) begin
              valid_q <= valid_q & seen_q;
              seen_q  <= '0;
              area_q  <= '0;
            end
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ src/ctc_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module ctc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ src/ctc_dist.sv @@
// Two-stage squared centroid distance unit shared by every slot of the scan.
`default_nettype none

module ctc_dist (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire ctc_pkg::entry_t                rd_entry_i,
  input  wire logic [ctc_pkg::COORD_W-1:0]    ref_x_i,
  input  wire logic [ctc_pkg::COORD_W-1:0]    ref_y_i,
  input  wire ctc_pkg::dtag_t                 tag_i,
  output      logic [ctc_pkg::DIST_W-1:0]     dist_o,
  output      ctc_pkg::dtag_t                 tag_o
);

  logic [ctc_pkg::COORD_W-1:0]   adx_d, ady_d, adx_q, ady_q;
  logic [2*ctc_pkg::COORD_W-1:0] sqx_q, sqy_q;
  ctc_pkg::dtag_t                tag_a_q, tag_b_q;

  assign adx_d = (rd_entry_i.cx >= ref_x_i) ? rd_entry_i.cx - ref_x_i
                                            : ref_x_i - rd_entry_i.cx;
  assign ady_d = (rd_entry_i.cy >= ref_y_i) ? rd_entry_i.cy - ref_y_i
                                            : ref_y_i - rd_entry_i.cy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_a_q <= '0;
      tag_b_q <= '0;
    end else begin
      tag_a_q <= tag_i;
      tag_b_q <= tag_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    adx_q <= adx_d;
    ady_q <= ady_d;
    sqx_q <= adx_q * adx_q;
    sqy_q <= ady_q * ady_q;
  end

  assign dist_o = {1'b0, sqx_q} + {1'b0, sqy_q};
  assign tag_o  = tag_b_q;

endmodule

`default_nettype wire
